// ===== src/r2y_pkg.sv =====
// ----------------------------------------------------------------------------
// r2y_pkg: shared constants for the RGB to 4:2:2 YUV pair converter
// Pixel widths, product ordering and the color matrix given to four decimals.
// ----------------------------------------------------------------------------
package r2y_pkg;

  // Default number of fraction bits in the fixed-point coefficients
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 6;   // red_a, green_a, blue_a, red_b, green_b, blue_b
  localparam int NUM_OUT    = 4;   // luma_a, luma_b, chroma_u, chroma_v
  localparam int NUM_PROD   = 12;  // three products for each of the four sums

  // Headroom bits of the signed accumulator above the fraction bits
  localparam int ACC_INT_W  = 11;

  // Base index of each product group, then the color inside a group
  localparam int PROD_YA = 0;
  localparam int PROD_YB = 3;
  localparam int PROD_U  = 6;
  localparam int PROD_V  = 9;
  localparam int CH_R    = 0;
  localparam int CH_G    = 1;
  localparam int CH_B    = 2;

  // Coefficient magnitudes in units of 1/10000, in product order
  localparam int COEF_M [NUM_PROD] = '{
    2990, 5870, 1140,   // luma, first pixel
    2990, 5870, 1140,   // luma, second pixel
    1686, 3311, 4997,   // U: -R -G +B
    4998, 4185,  813    // V: +R -G -B
  };

  localparam int CHROMA_OFFSET = 128;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

endpackage

// ===== src/r2y_prod.sv =====
// ----------------------------------------------------------------------------
// r2y_prod: coefficient multiply stage
// Forms the twelve unsigned coefficient products of one pixel pair.
// ----------------------------------------------------------------------------
module r2y_prod #(
  parameter int COEF_FRAC_BITS = r2y_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [r2y_pkg::PIX_W-1:0] pix [r2y_pkg::NUM_CH],
  output logic out_valid,
  input  logic out_ready,
  output logic [COEF_FRAC_BITS+r2y_pkg::PIX_W-1:0] prod [r2y_pkg::NUM_PROD]
);

  localparam int CW = COEF_FRAC_BITS;
  localparam int PW = COEF_FRAC_BITS + r2y_pkg::PIX_W;

  logic [PW-1:0] prod_next [r2y_pkg::NUM_PROD];

  assign in_ready = !out_valid || out_ready;

  for (genvar i = 0; i < r2y_pkg::NUM_PROD; i++) begin : g_mul
    // round(|c| * 2^F), ties upward
    localparam longint CFULL =
      ((longint'(r2y_pkg::COEF_M[i]) << COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
    localparam logic [CW-1:0] COEF = CW'(CFULL);
    // second luma group takes the second pixel, all others the first
    localparam int SEL = ((i / 3) == 1) ? (3 + (i % 3)) : (i % 3);

    assign prod_next[i] = PW'(pix[SEL]) * PW'(COEF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== src/r2y_acc.sv =====
// ----------------------------------------------------------------------------
// r2y_acc: signed sum stage
// Adds the signed products, the rounding half and, for U and V, the chroma offset.
// ----------------------------------------------------------------------------
module r2y_acc #(
  parameter int COEF_FRAC_BITS = r2y_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COEF_FRAC_BITS+r2y_pkg::PIX_W-1:0] prod [r2y_pkg::NUM_PROD],
  output logic out_valid,
  input  logic out_ready,
  output logic signed [COEF_FRAC_BITS+r2y_pkg::ACC_INT_W-1:0] acc [r2y_pkg::NUM_OUT]
);

  localparam int PW = COEF_FRAC_BITS + r2y_pkg::PIX_W;
  localparam int AW = COEF_FRAC_BITS + r2y_pkg::ACC_INT_W;

  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] OFFS =
    AW'(r2y_pkg::CHROMA_OFFSET) <<< COEF_FRAC_BITS;

  logic signed [AW-1:0] ext [r2y_pkg::NUM_PROD];
  logic signed [AW-1:0] acc_next [r2y_pkg::NUM_OUT];

  assign in_ready = !out_valid || out_ready;

  for (genvar i = 0; i < r2y_pkg::NUM_PROD; i++) begin : g_ext
    assign ext[i] = signed'({{(AW-PW){1'b0}}, prod[i]});
  end

  always_comb begin
    acc_next[0] = ext[r2y_pkg::PROD_YA + r2y_pkg::CH_R] + ext[r2y_pkg::PROD_YA + r2y_pkg::CH_G]
                + ext[r2y_pkg::PROD_YA + r2y_pkg::CH_B] + HALF;
    acc_next[1] = ext[r2y_pkg::PROD_YB + r2y_pkg::CH_R] + ext[r2y_pkg::PROD_YB + r2y_pkg::CH_G]
                + ext[r2y_pkg::PROD_YB + r2y_pkg::CH_B] + HALF;
    acc_next[2] = ext[r2y_pkg::PROD_U + r2y_pkg::CH_B] - ext[r2y_pkg::PROD_U + r2y_pkg::CH_R]
                - ext[r2y_pkg::PROD_U + r2y_pkg::CH_G] + (OFFS + HALF);
    acc_next[3] = ext[r2y_pkg::PROD_V + r2y_pkg::CH_R] - ext[r2y_pkg::PROD_V + r2y_pkg::CH_G]
                - ext[r2y_pkg::PROD_V + r2y_pkg::CH_B] + (OFFS + HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== src/r2y_clip.sv =====
// ----------------------------------------------------------------------------
// r2y_clip: round and clamp stage, output register
// Drops the fraction bits and clamps each sum to 0..255.
// ----------------------------------------------------------------------------
module r2y_clip #(
  parameter int COEF_FRAC_BITS = r2y_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [COEF_FRAC_BITS+r2y_pkg::ACC_INT_W-1:0] acc [r2y_pkg::NUM_OUT],
  output logic out_valid,
  input  logic out_ready,
  output logic [r2y_pkg::PIX_W-1:0] res [r2y_pkg::NUM_OUT]
);

  localparam int AW = COEF_FRAC_BITS + r2y_pkg::ACC_INT_W;
  localparam int QW = r2y_pkg::ACC_INT_W - 1;  // integer part without sign

  logic [r2y_pkg::PIX_W-1:0] res_next [r2y_pkg::NUM_OUT];

  assign in_ready = !out_valid || out_ready;

  for (genvar i = 0; i < r2y_pkg::NUM_OUT; i++) begin : g_clip
    logic [QW-1:0] q;
    assign q = acc[i][AW-2:COEF_FRAC_BITS];
    always_comb begin
      if (acc[i][AW-1]) begin
        res_next[i] = '0;
      end else if (q > QW'(r2y_pkg::PIX_MAX)) begin
        res_next[i] = r2y_pkg::PIX_MAX;
      end else begin
        res_next[i] = q[r2y_pkg::PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/rgb_to_yuv422_pair.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv422_pair: RGB pixel pair to 4:2:2 YUV converter
// Converts two adjacent 8-bit RGB pixels to two lumas and one U/V pair.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_t*) takes one pair of horizontally adjacent pixels per
//   item; master channel (m_t*) gives Y of both pixels plus U and V of the
//   first pixel, U and V offset, all rounded to nearest (ties up) and clamped.
//   Throughput: one pair per clock while m_tready is high. Each of the three register
//   stages (coefficient multiplies, signed sums, round/clamp) takes a new
//   item every cycle while the stage ahead of it moves or is empty.
//   Stall: when m_tready is low, the result holds in the output register;
//   items behind it advance into empty stages and s_tready drops only once
//   all three stages are full. Nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) empties the pipeline; no item is
//   in flight afterwards and there is no further initialization.
//   COEF_FRAC_BITS (10..20) sets the coefficient fraction bits and with it
//   the width of the products and sums.
// ----------------------------------------------------------------------------
module rgb_to_yuv422_pair #(
  parameter int COEF_FRAC_BITS = r2y_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // red_a, green_a, blue_a, red_b, green_b, blue_b
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // luma_a, luma_b, chroma_u, chroma_v
);

  localparam int PIXW = r2y_pkg::PIX_W;
  localparam int PW   = COEF_FRAC_BITS + r2y_pkg::PIX_W;
  localparam int AW   = COEF_FRAC_BITS + r2y_pkg::ACC_INT_W;

  logic [PIXW-1:0] pix [r2y_pkg::NUM_CH];
  logic [PW-1:0]   prod [r2y_pkg::NUM_PROD];
  logic signed [AW-1:0] acc [r2y_pkg::NUM_OUT];
  logic [PIXW-1:0] res [r2y_pkg::NUM_OUT];

  logic prod_valid, prod_ready;
  logic acc_valid, acc_ready;

  // Unpack the input item, first field in the lowest byte
  for (genvar i = 0; i < r2y_pkg::NUM_CH; i++) begin : g_unpack
    assign pix[i] = s_tdata[i*PIXW +: PIXW];
  end

  r2y_prod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pix       (pix),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .prod      (prod)
  );

  r2y_acc #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .prod      (prod),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .acc       (acc)
  );

  r2y_clip #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_clip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .acc       (acc),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // Pack the result item, luma_a in the lowest byte
  for (genvar i = 0; i < r2y_pkg::NUM_OUT; i++) begin : g_pack
    assign m_tdata[i*PIXW +: PIXW] = res[i];
  end

endmodule
